@@ rtl/core/bli_pkg.sv @@
// Shared widths, types and constants of the bilinear interpolation block.
package bli_pkg;

    // Widths of values, differences, products and the division datapath.
    localparam int VALUE_W = 32;
    localparam int DIFF_W  = VALUE_W + 1;
    localparam int MAG_W   = VALUE_W;
    localparam int PROD_W  = 2 * MAG_W;
    localparam int TERM_W  = 3 * MAG_W;
    localparam int ACC_W   = TERM_W + 2;
    localparam int QUO_W   = VALUE_W + 1;

    typedef logic signed [VALUE_W-1:0] value_t;
    typedef logic signed [DIFF_W-1:0]  diff_t;
    typedef logic        [MAG_W-1:0]   mag_t;
    typedef logic        [PROD_W-1:0]  prod_t;
    typedef logic        [TERM_W-1:0]  term_t;
    typedef logic signed [ACC_W-1:0]   acc_t;
    typedef logic        [ACC_W-1:0]   rem_t;
    typedef logic        [QUO_W-1:0]   quo_t;

    // Saturation limits of the quotient magnitude and of the output value.
    localparam quo_t   LIM_POS = {2'b00, {(VALUE_W-1){1'b1}}};
    localparam quo_t   LIM_NEG = {2'b01, {(VALUE_W-1){1'b0}}};
    localparam value_t VAL_MAX = {1'b0, {(VALUE_W-1){1'b1}}};
    localparam value_t VAL_MIN = {1'b1, {(VALUE_W-1){1'b0}}};

    // Operands handed to the divider pipeline.
    typedef struct packed {
        logic  degen;
        logic  neg;
        rem_t  mag;
        prod_t den;
    } div_in_t;

    // Word carried by each divider stage.
    typedef struct packed {
        logic  degen;
        logic  neg;
        logic  ovf;
        rem_t  rem;
        prod_t den;
        quo_t  quo;
    } div_word_t;

endpackage

@@ rtl/core/bli_in_if.sv @@
// Input channel of the bilinear interpolation block.
interface bli_in_if import bli_pkg::*; ();

    logic   valid;
    logic   ready;
    value_t corner_lo_lo;
    value_t corner_lo_hi;
    value_t corner_hi_lo;
    value_t corner_hi_hi;
    value_t left_x;
    value_t right_x;
    value_t bottom_y;
    value_t top_y;
    value_t query_x;
    value_t query_y;

    modport source (
        output valid,
        input  ready,
        output corner_lo_lo, corner_lo_hi, corner_hi_lo, corner_hi_hi,
        output left_x, right_x, bottom_y, top_y, query_x, query_y
    );

    modport sink (
        input  valid,
        output ready,
        input  corner_lo_lo, corner_lo_hi, corner_hi_lo, corner_hi_hi,
        input  left_x, right_x, bottom_y, top_y, query_x, query_y
    );

endinterface

@@ rtl/core/bli_out_if.sv @@
// Output channel of the bilinear interpolation block.
interface bli_out_if import bli_pkg::*; ();

    logic   valid;
    logic   ready;
    value_t interpolated;
    logic   degenerate_cell;
    logic   saturated;

    modport source (
        output valid,
        input  ready,
        output interpolated, degenerate_cell, saturated
    );

    modport sink (
        input  valid,
        output ready,
        input  interpolated, degenerate_cell, saturated
    );

endinterface

@@ rtl/core/bli_divider.sv @@
// Pipelined restoring divider: one quotient bit per stage plus an overflow check.
module bli_divider
    import bli_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      en,
    input  logic      in_valid,
    input  div_in_t   in_word,
    output logic      out_valid,
    output div_word_t out_word
);

    logic [QUO_W:0] vld_reg;
    logic [QUO_W:0] vld_next;
    div_word_t      st_reg  [QUO_W+1];
    div_word_t      st_next [QUO_W+1];

    // First stage flags quotients that do not fit in QUO_W bits.
    always_comb
    begin
        st_next[0].degen = in_word.degen;
        st_next[0].neg   = in_word.neg;
        st_next[0].rem   = in_word.mag;
        st_next[0].den   = in_word.den;
        st_next[0].quo   = '0;
        st_next[0].ovf   = in_word.mag >= (rem_t'(in_word.den) << QUO_W);
    end

    // Each later stage decides one quotient bit, most significant first.
    for (genvar j = 1; j <= QUO_W; j++)
    begin : g_step
        rem_t sub_cand;
        logic fits;

        always_comb
        begin
            sub_cand   = rem_t'(st_reg[j-1].den) << (QUO_W - j);
            fits       = st_reg[j-1].rem >= sub_cand;
            st_next[j] = st_reg[j-1];
            if (fits)
            begin
                st_next[j].rem           = st_reg[j-1].rem - sub_cand;
                st_next[j].quo[QUO_W-j] = 1'b1;
            end
        end
    end

    assign vld_next = {vld_reg[QUO_W-1:0], in_valid};

    // Valid bits travel with the data and freeze with it.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (en)
        begin
            vld_reg <= vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            st_reg <= st_next;
        end
    end

    assign out_valid = vld_reg[QUO_W];
    assign out_word  = st_reg[QUO_W];

endmodule

@@ rtl/core/bilinear_interpolation.sv @@
// Top level of the pipelined fixed-point bilinear interpolator.
//
// One word on the sample channel carries four corner values, the cell bounds
// and a query point, all signed Q16.16. One word on the result channel returns
// the interpolated value, truncated toward zero and saturated, plus flags for
// a zero-area cell and for clipping. Every sample word yields one result word,
// in order.
// The pipeline has nine stages of differences, products and summing, one
// overflow stage, then a divider that settles one quotient bit per stage
// over 33 stages, and the output register. It takes one word per cycle
// while the skid register is empty; the divider stages set the depth, the
// 32x32 multipliers set the width of each stage.
// Reset clears every valid bit, so the pipeline starts empty.
// When the receiver stalls, one more word lands in a skid register and the
// pipeline then holds; sample.ready stays high until that skid register fills
// and comes back as soon as it drains.
module bilinear_interpolation
    import bli_pkg::*;
(
    input  logic   clk,
    input  logic   rst_n,
    bli_in_if.sink   sample,
    bli_out_if.source result
);

    localparam int FRONT_STAGES = 9;
    localparam int T_LL = 0;
    localparam int T_HL = 1;
    localparam int T_LH = 2;
    localparam int T_HH = 3;

    typedef struct packed {
        value_t q_ll;
        value_t q_lh;
        value_t q_hl;
        value_t q_hh;
        diff_t  dx;
        diff_t  dy;
        diff_t  rx;
        diff_t  ry;
        diff_t  lx;
        diff_t  ly;
    } s1_t;

    typedef struct packed {
        mag_t [3:0] mq;
        mag_t       m_dx;
        mag_t       m_dy;
        mag_t       m_rx;
        mag_t       m_ry;
        mag_t       m_lx;
        mag_t       m_ly;
        logic [3:0] t_neg;
        logic       d_neg;
        logic       degen;
    } s2_t;

    typedef struct packed {
        mag_t  [3:0] mq;
        prod_t [3:0] w;
        prod_t       den;
        logic  [3:0] t_neg;
        logic        d_neg;
        logic        degen;
    } s3_t;

    typedef struct packed {
        prod_t [3:0] plo;
        prod_t [3:0] phi;
        prod_t       den;
        logic  [3:0] t_neg;
        logic        d_neg;
        logic        degen;
    } s4_t;

    typedef struct packed {
        term_t [3:0] tm;
        prod_t       den;
        logic  [3:0] t_neg;
        logic        d_neg;
        logic        degen;
    } s5_t;

    typedef struct packed {
        acc_t [3:0] ts;
        prod_t      den;
        logic       d_neg;
        logic       degen;
    } s6_t;

    typedef struct packed {
        acc_t [1:0] ps;
        prod_t      den;
        logic       d_neg;
        logic       degen;
    } s7_t;

    typedef struct packed {
        acc_t  acc;
        prod_t den;
        logic  d_neg;
        logic  degen;
    } s8_t;

    typedef struct packed {
        value_t interpolated;
        logic   degenerate_cell;
        logic   saturated;
    } res_t;

    function automatic mag_t mag_of(diff_t d);
        diff_t n;
        n = -d;
        return d[DIFF_W-1] ? mag_t'(n) : mag_t'(d);
    endfunction

    logic                    en;
    logic                    accept;
    logic [FRONT_STAGES-1:0] vld_reg;
    logic [FRONT_STAGES-1:0] vld_next;
    s1_t                     s1_reg, s1_next;
    s2_t                     s2_reg, s2_next;
    s3_t                     s3_reg, s3_next;
    s4_t                     s4_reg, s4_next;
    s5_t                     s5_reg, s5_next;
    s6_t                     s6_reg, s6_next;
    s7_t                     s7_reg, s7_next;
    s8_t                     s8_reg, s8_next;
    div_in_t                 s9_reg, s9_next;
    logic                    dv_valid;
    div_word_t               dv_word;
    quo_t                    limit;
    quo_t                    mag_sat;
    quo_t                    signed_q;
    logic                    sat;
    res_t                    fin_word;
    logic                    out_take;
    logic                    load_out;
    logic                    load_skid;
    logic                    out_from_skid;
    logic                    out_valid_reg, out_valid_next;
    logic                    skid_valid_reg, skid_valid_next;
    res_t                    out_word_reg, out_word_next;
    res_t                    skid_word_reg, skid_word_next;

    // The pipeline moves whenever the skid register is free.
    assign en           = !skid_valid_reg;
    assign sample.ready = en;
    assign accept       = sample.valid && en;
    assign vld_next     = {vld_reg[FRONT_STAGES-2:0], accept};

    // Stage 1: signed differences of bounds and query point.
    always_comb
    begin
        s1_next.q_ll = sample.corner_lo_lo;
        s1_next.q_lh = sample.corner_lo_hi;
        s1_next.q_hl = sample.corner_hi_lo;
        s1_next.q_hh = sample.corner_hi_hi;
        s1_next.dx   = diff_t'(sample.right_x) - diff_t'(sample.left_x);
        s1_next.dy   = diff_t'(sample.top_y)   - diff_t'(sample.bottom_y);
        s1_next.rx   = diff_t'(sample.right_x) - diff_t'(sample.query_x);
        s1_next.ry   = diff_t'(sample.top_y)   - diff_t'(sample.query_y);
        s1_next.lx   = diff_t'(sample.query_x) - diff_t'(sample.left_x);
        s1_next.ly   = diff_t'(sample.query_y) - diff_t'(sample.bottom_y);
    end

    // Stage 2: magnitudes and the sign of each weighted term.
    always_comb
    begin
        s2_next.mq[T_LL] = mag_of(diff_t'(s1_reg.q_ll));
        s2_next.mq[T_HL] = mag_of(diff_t'(s1_reg.q_hl));
        s2_next.mq[T_LH] = mag_of(diff_t'(s1_reg.q_lh));
        s2_next.mq[T_HH] = mag_of(diff_t'(s1_reg.q_hh));
        s2_next.m_dx     = mag_of(s1_reg.dx);
        s2_next.m_dy     = mag_of(s1_reg.dy);
        s2_next.m_rx     = mag_of(s1_reg.rx);
        s2_next.m_ry     = mag_of(s1_reg.ry);
        s2_next.m_lx     = mag_of(s1_reg.lx);
        s2_next.m_ly     = mag_of(s1_reg.ly);
        s2_next.t_neg[T_LL] = s1_reg.q_ll[VALUE_W-1] ^ s1_reg.rx[DIFF_W-1]
                              ^ s1_reg.ry[DIFF_W-1];
        s2_next.t_neg[T_HL] = s1_reg.q_hl[VALUE_W-1] ^ s1_reg.lx[DIFF_W-1]
                              ^ s1_reg.ry[DIFF_W-1];
        s2_next.t_neg[T_LH] = s1_reg.q_lh[VALUE_W-1] ^ s1_reg.rx[DIFF_W-1]
                              ^ s1_reg.ly[DIFF_W-1];
        s2_next.t_neg[T_HH] = s1_reg.q_hh[VALUE_W-1] ^ s1_reg.lx[DIFF_W-1]
                              ^ s1_reg.ly[DIFF_W-1];
        s2_next.d_neg = s1_reg.dx[DIFF_W-1] ^ s1_reg.dy[DIFF_W-1];
        s2_next.degen = (s1_reg.dx == '0) || (s1_reg.dy == '0);
    end

    // Stage 3: sub-rectangle areas and the cell area.
    always_comb
    begin
        s3_next.mq       = s2_reg.mq;
        s3_next.w[T_LL]  = prod_t'(s2_reg.m_rx) * prod_t'(s2_reg.m_ry);
        s3_next.w[T_HL]  = prod_t'(s2_reg.m_lx) * prod_t'(s2_reg.m_ry);
        s3_next.w[T_LH]  = prod_t'(s2_reg.m_rx) * prod_t'(s2_reg.m_ly);
        s3_next.w[T_HH]  = prod_t'(s2_reg.m_lx) * prod_t'(s2_reg.m_ly);
        s3_next.den      = prod_t'(s2_reg.m_dx) * prod_t'(s2_reg.m_dy);
        s3_next.t_neg    = s2_reg.t_neg;
        s3_next.d_neg    = s2_reg.d_neg;
        s3_next.degen    = s2_reg.degen;
    end

    // Stage 4: corner times area, split into low and high partial products.
    always_comb
    begin
        for (int i = 0; i < 4; i++)
        begin
            s4_next.plo[i] = prod_t'(s3_reg.mq[i]) * prod_t'(s3_reg.w[i][MAG_W-1:0]);
            s4_next.phi[i] = prod_t'(s3_reg.mq[i]) * prod_t'(s3_reg.w[i][PROD_W-1:MAG_W]);
        end
        s4_next.den   = s3_reg.den;
        s4_next.t_neg = s3_reg.t_neg;
        s4_next.d_neg = s3_reg.d_neg;
        s4_next.degen = s3_reg.degen;
    end

    // Stage 5: join the partial products into full term magnitudes.
    always_comb
    begin
        for (int i = 0; i < 4; i++)
        begin
            s5_next.tm[i] = term_t'(s4_reg.plo[i]) + (term_t'(s4_reg.phi[i]) << MAG_W);
        end
        s5_next.den   = s4_reg.den;
        s5_next.t_neg = s4_reg.t_neg;
        s5_next.d_neg = s4_reg.d_neg;
        s5_next.degen = s4_reg.degen;
    end

    // Stage 6: apply the sign of each term.
    always_comb
    begin
        for (int i = 0; i < 4; i++)
        begin
            s6_next.ts[i] = s5_reg.t_neg[i] ? -acc_t'(s5_reg.tm[i]) : acc_t'(s5_reg.tm[i]);
        end
        s6_next.den   = s5_reg.den;
        s6_next.d_neg = s5_reg.d_neg;
        s6_next.degen = s5_reg.degen;
    end

    // Stage 7: pairwise sums.
    always_comb
    begin
        s7_next.ps[0] = $signed(s6_reg.ts[0]) + $signed(s6_reg.ts[1]);
        s7_next.ps[1] = $signed(s6_reg.ts[2]) + $signed(s6_reg.ts[3]);
        s7_next.den   = s6_reg.den;
        s7_next.d_neg = s6_reg.d_neg;
        s7_next.degen = s6_reg.degen;
    end

    // Stage 8: full weighted sum.
    always_comb
    begin
        s8_next.acc   = $signed(s7_reg.ps[0]) + $signed(s7_reg.ps[1]);
        s8_next.den   = s7_reg.den;
        s8_next.d_neg = s7_reg.d_neg;
        s8_next.degen = s7_reg.degen;
    end

    // Stage 9: magnitude of the sum and sign of the quotient.
    always_comb
    begin
        s9_next.mag   = s8_reg.acc[ACC_W-1] ? rem_t'(-s8_reg.acc) : rem_t'(s8_reg.acc);
        s9_next.neg   = s8_reg.acc[ACC_W-1] ^ s8_reg.d_neg;
        s9_next.den   = s8_reg.den;
        s9_next.degen = s8_reg.degen;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (en)
        begin
            vld_reg <= vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s1_reg <= s1_next;
            s2_reg <= s2_next;
            s3_reg <= s3_next;
            s4_reg <= s4_next;
            s5_reg <= s5_next;
            s6_reg <= s6_next;
            s7_reg <= s7_next;
            s8_reg <= s8_next;
            s9_reg <= s9_next;
        end
    end

    bli_divider u_divider (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (vld_reg[FRONT_STAGES-1]),
        .in_word   (s9_reg),
        .out_valid (dv_valid),
        .out_word  (dv_word)
    );

    // Saturate the quotient, restore its sign, and handle a zero-area cell.
    always_comb
    begin
        limit    = dv_word.neg ? LIM_NEG : LIM_POS;
        sat      = dv_word.ovf || (dv_word.quo > limit);
        mag_sat  = sat ? limit : dv_word.quo;
        signed_q = dv_word.neg ? (~mag_sat + quo_t'(1)) : mag_sat;
        if (dv_word.degen)
        begin
            fin_word.interpolated    = '0;
            fin_word.degenerate_cell = 1'b1;
            fin_word.saturated       = 1'b0;
        end
        else
        begin
            fin_word.interpolated    = value_t'(signed_q[VALUE_W-1:0]);
            fin_word.degenerate_cell = 1'b0;
            fin_word.saturated       = sat;
        end
    end

    // Output register with a one-word skid register behind it.
    assign out_take = out_valid_reg && result.ready;

    always_comb
    begin
        out_valid_next  = out_valid_reg;
        skid_valid_next = skid_valid_reg;
        load_out        = 1'b0;
        load_skid       = 1'b0;
        out_from_skid   = 1'b0;
        priority if (skid_valid_reg)
        begin
            if (out_take)
            begin
                out_from_skid   = 1'b1;
                skid_valid_next = 1'b0;
            end
        end
        else if (dv_valid)
        begin
            if (!out_valid_reg || result.ready)
            begin
                load_out       = 1'b1;
                out_valid_next = 1'b1;
            end
            else
            begin
                load_skid       = 1'b1;
                skid_valid_next = 1'b1;
            end
        end
        else if (out_take)
        begin
            out_valid_next = 1'b0;
        end
        out_word_next  = out_from_skid ? skid_word_reg
                       : (load_out ? fin_word : out_word_reg);
        skid_word_next = load_skid ? fin_word : skid_word_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_word_reg  <= out_word_next;
        skid_word_reg <= skid_word_next;
    end

    assign result.valid           = out_valid_reg;
    assign result.interpolated    = out_word_reg.interpolated;
    assign result.degenerate_cell = out_word_reg.degenerate_cell;
    assign result.saturated       = out_word_reg.saturated;

endmodule

@@ rtl/core/bli_checker.sv @@
// Port-level assertions for the bilinear interpolator and their binding.
module bli_checker
    import bli_pkg::*;
(
    input logic   clk,
    input logic   rst_n,
    input logic   in_valid,
    input logic   in_ready,
    input logic   out_valid,
    input logic   out_ready,
    input value_t interpolated,
    input logic   degenerate_cell,
    input logic   saturated
);

    localparam int CNT_W = 8;

    logic [CNT_W-1:0] inflight_reg;
    logic [CNT_W-1:0] inflight_next;

    // Count words accepted but not yet delivered.
    always_comb
    begin
        inflight_next = inflight_reg;
        if (in_valid && in_ready)
        begin
            inflight_next = inflight_next + CNT_W'(1);
        end
        if (out_valid && out_ready)
        begin
            inflight_next = inflight_next - CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            inflight_reg <= '0;
        end
        else
        begin
            inflight_reg <= inflight_next;
        end
    end

    // A result never appears without an accepted word behind it.
    a_no_invented: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> inflight_reg != '0)
        else $error("result word without a pending sample word");

    // A zero-area cell gives zero and never reports clipping.
    a_degen_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && degenerate_cell |-> interpolated == '0 && !saturated)
        else $error("degenerate cell with nonzero result or clipping flag");

    // A clipped result sits at one of the range limits.
    a_sat_limit: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && saturated |-> interpolated == VAL_MAX || interpolated == VAL_MIN)
        else $error("clipped result not at a range limit");

    // A stalled result word holds.
    a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(interpolated)
            && $stable(degenerate_cell) && $stable(saturated))
        else $error("stalled result word changed");

    // Nothing is offered once a clock edge has seen reset.
    a_reset_quiet: assert property (@(posedge clk)
        !rst_n |=> !out_valid)
        else $error("result valid during reset");

endmodule

bind bilinear_interpolation bli_checker u_bli_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (sample.valid),
    .in_ready        (sample.ready),
    .out_valid       (result.valid),
    .out_ready       (result.ready),
    .interpolated    (result.interpolated),
    .degenerate_cell (result.degenerate_cell),
    .saturated       (result.saturated)
);
